### rtl/cjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjd_pkg
// Shared types, constants and an arithmetic helper of the clock jump detector.
// ----------------------------------------------------------------------------
package cjd_pkg;

	localparam int unsigned TIME_W    = 64;
	localparam int unsigned CAP_W     = 2;
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [TIME_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [TIME_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;

	localparam logic [TIME_W-1:0] GRACE_RESET   = 64'd60000;
	localparam logic [TIME_W-1:0] THR_RESET     = 64'd5000;
	// two's complement of the reset threshold
	localparam logic [TIME_W-1:0] THR_NEG_RESET = 64'hFFFF_FFFF_FFFF_EC78;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRACE_WINDOW   = 4'd0,
		REG_JUMP_THRESHOLD = 4'd1
	} cfg_reg_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [TIME_W-1:0] grace_window;
		logic [TIME_W-1:0] thr_mag;
		logic [TIME_W-1:0] thr_neg;
	} cfg_t;

	// status bits that travel unchanged
	typedef struct packed {
		logic [CAP_W-1:0] capability;
		logic             sync_status_known;
		logic             sync_ok;
	} status_t;

	// saturating signed subtraction a - b
	function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		if ((a[TIME_W-1] != b[TIME_W-1]) && (a[TIME_W-1] != d[TIME_W-1])) begin
			return a[TIME_W-1] ? S64_MIN : S64_MAX;
		end
		return d;
	endfunction

endpackage

### rtl/cjd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjd channel interfaces
// Sample, result and configuration write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cjd_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [cjd_pkg::TIME_W-1:0]     wall_time_ms;
	logic        [cjd_pkg::TIME_W-1:0]     steady_time_ms;
	logic                                  sync_status_known;
	logic                                  sync_ok;
	logic        [cjd_pkg::CAP_W-1:0]      capability_in;

	modport source (output valid, wall_time_ms, steady_time_ms, sync_status_known,
		sync_ok, capability_in, input ready);
	modport sink (input valid, wall_time_ms, steady_time_ms, sync_status_known,
		sync_ok, capability_in, output ready);
endinterface

interface cjd_result_if;
	logic                                  valid;
	logic                                  ready;
	logic        [cjd_pkg::CAP_W-1:0]      capability_out;
	logic                                  sync_status_known_out;
	logic                                  sync_ok_out;
	logic signed [cjd_pkg::TIME_W-1:0]     jump_amount_ms;
	logic                                  jump_flag;
	logic                                  grace_active;

	modport source (output valid, capability_out, sync_status_known_out, sync_ok_out,
		jump_amount_ms, jump_flag, grace_active, input ready);
	modport sink (input valid, capability_out, sync_status_known_out, sync_ok_out,
		jump_amount_ms, jump_flag, grace_active, output ready);
endinterface

interface cjd_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [cjd_pkg::CFG_IDX_W-1:0]         index;
	logic [cjd_pkg::TIME_W-1:0]            data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/cjd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjd_cfg
// Configuration registers; the threshold is kept as magnitude and its negation.
// ----------------------------------------------------------------------------
module cjd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	cjd_cfg_if.sink           cfg,
	output cjd_pkg::cfg_t     regs
);

	logic [cjd_pkg::TIME_W-1:0] grace_q;
	logic [cjd_pkg::TIME_W-1:0] thr_mag_q;
	logic [cjd_pkg::TIME_W-1:0] thr_neg_q;
	logic [cjd_pkg::TIME_W-1:0] data_neg;
	logic [cjd_pkg::TIME_W-1:0] mag_nxt;
	logic [cjd_pkg::TIME_W-1:0] neg_nxt;

	assign cfg.ready = 1'b1;
	assign data_neg  = ~cfg.data + cjd_pkg::TIME_W'(1);

	// most negative value stands for the largest magnitude
	always_comb begin
		if (cfg.data == cjd_pkg::S64_MIN) begin
			mag_nxt = cjd_pkg::S64_MAX;
			neg_nxt = cjd_pkg::S64_MIN + cjd_pkg::TIME_W'(1);
		end else if (cfg.data[cjd_pkg::TIME_W-1]) begin
			mag_nxt = data_neg;
			neg_nxt = cfg.data;
		end else begin
			mag_nxt = cfg.data;
			neg_nxt = data_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q   <= cjd_pkg::GRACE_RESET;
			thr_mag_q <= cjd_pkg::THR_RESET;
			thr_neg_q <= cjd_pkg::THR_NEG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cjd_pkg::REG_GRACE_WINDOW: begin
					grace_q <= cfg.data;
				end
				cjd_pkg::REG_JUMP_THRESHOLD: begin
					thr_mag_q <= mag_nxt;
					thr_neg_q <= neg_nxt;
				end
				default: begin
				end
			endcase
		end
	end

	assign regs.grace_window = grace_q;
	assign regs.thr_mag      = thr_mag_q;
	assign regs.thr_neg      = thr_neg_q;

	a_thr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		thr_neg_q == ~thr_mag_q + cjd_pkg::TIME_W'(1))
		else $error("threshold negation out of step with magnitude");

	a_thr_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!thr_mag_q[cjd_pkg::TIME_W-1])
		else $error("threshold magnitude negative");

	a_grace_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.index == cjd_pkg::REG_GRACE_WINDOW) |=> (grace_q == $past(cfg.data)))
		else $error("grace window write not taken");

endmodule

### rtl/clock_jump_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_jump_detector
// Flags wall-clock jumps against a monotonic clock, with a startup grace flag.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while the pipeline is not stalled and returns one
// result per sample through the four-stage pipeline (input register, deltas,
// saturated jump, threshold compare); bubbles are squeezed out when the result
// side stalls. The first sample after reset
// opens the grace window and yields a zero jump, as does any sample whose
// monotonic time went backward or advanced by more than the signed 64-bit
// range. Configuration writes are taken at any time and must only be issued
// while no sample is in flight.
module clock_jump_detector (
	input  logic          clk,
	input  logic          arst_n,
	cjd_sample_if.sink    sample,
	cjd_result_if.source  result,
	cjd_cfg_if.sink       cfg
);

	localparam int unsigned W = cjd_pkg::TIME_W;

	cjd_pkg::cfg_t regs;

	cjd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// running state
	logic         seen_first_q;
	logic [W-1:0] first_steady_q;
	logic [W-1:0] last_wall_q;
	logic [W-1:0] last_steady_q;

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4 = !v_s4 || result.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign sample.ready = en_s1;

	logic accept;
	assign accept = sample.valid && en_s1;

	// stage 1 registers
	cjd_pkg::status_t st_s1;
	logic [W-1:0]     wall_s1, steady_s1, prev_wall_s1, prev_steady_s1, first_s1;
	logic             seen_s1;

	// stage 2 registers
	cjd_pkg::status_t st_s2;
	logic [W-1:0]     mdelta_s2, wdelta_s2, gdiff_s2;
	logic             do_jump_s2, gbefore_s2;

	// stage 3 registers
	cjd_pkg::status_t st_s3;
	logic [W-1:0]     jump_s3;
	logic             grace_s3;

	// stage 4 registers
	cjd_pkg::status_t st_s4;
	logic [W-1:0]     jump_s4;
	logic             flag_s4, grace_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q   <= 1'b0;
			first_steady_q <= '0;
			last_wall_q    <= '0;
			last_steady_q  <= '0;
		end else if (accept) begin
			seen_first_q  <= 1'b1;
			last_wall_q   <= sample.wall_time_ms;
			last_steady_q <= sample.steady_time_ms;
			if (!seen_first_q) begin
				first_steady_q <= sample.steady_time_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= sample.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 1: capture the item with the state it sees
	always_ff @(posedge clk) begin
		if (en_s1) begin
			st_s1.capability        <= sample.capability_in;
			st_s1.sync_status_known <= sample.sync_status_known;
			st_s1.sync_ok           <= sample.sync_ok;
			wall_s1                 <= sample.wall_time_ms;
			steady_s1               <= sample.steady_time_ms;
			prev_wall_s1            <= last_wall_q;
			prev_steady_s1          <= last_steady_q;
			first_s1                <= seen_first_q ? first_steady_q : sample.steady_time_ms;
			seen_s1                 <= seen_first_q;
		end
	end

	// stage 2: monotonic delta, wall delta, offset into grace window
	logic [W:0] mdiff_ext, gdiff_ext;
	assign mdiff_ext = {1'b0, steady_s1} - {1'b0, prev_steady_s1};
	assign gdiff_ext = {1'b0, steady_s1} - {1'b0, first_s1};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			st_s2      <= st_s1;
			mdelta_s2  <= mdiff_ext[W-1:0];
			wdelta_s2  <= cjd_pkg::sat_sub(wall_s1, prev_wall_s1);
			// borrow means time went backward; top bit set means delta too large
			do_jump_s2 <= seen_s1 && !mdiff_ext[W] && !mdiff_ext[W-1];
			gdiff_s2   <= gdiff_ext[W-1:0];
			gbefore_s2 <= gdiff_ext[W];
		end
	end

	// stage 3: saturated jump, grace compare
	always_ff @(posedge clk) begin
		if (en_s3) begin
			st_s3    <= st_s2;
			jump_s3  <= do_jump_s2 ? cjd_pkg::sat_sub(wdelta_s2, mdelta_s2) : '0;
			grace_s3 <= !gbefore_s2 && (gdiff_s2 < regs.grace_window);
		end
	end

	// stage 4: threshold compare into the result register
	always_ff @(posedge clk) begin
		if (en_s4) begin
			st_s4    <= st_s3;
			jump_s4  <= jump_s3;
			flag_s4  <= ($signed(regs.thr_mag) < $signed(jump_s3)) ||
				($signed(jump_s3) < $signed(regs.thr_neg));
			grace_s4 <= grace_s3;
		end
	end

	assign result.valid                 = v_s4;
	assign result.capability_out        = st_s4.capability;
	assign result.sync_status_known_out = st_s4.sync_status_known;
	assign result.sync_ok_out           = st_s4.sync_ok;
	assign result.jump_amount_ms        = jump_s4;
	assign result.jump_flag             = flag_s4;
	assign result.grace_active          = grace_s4;

	a_first_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_first_q |=> seen_first_q)
		else $error("first-sample mark cleared without reset");

	a_first_no_jump: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s2 && v_s1 && !seen_s1) |=> !do_jump_s2)
		else $error("jump computed for the first sample");

	a_flag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && flag_s4) |-> (jump_s4 != '0))
		else $error("jump flagged with zero jump");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en_s2) |=> (v_s1 && $stable(wall_s1) && $stable(steady_s1)))
		else $error("stalled stage one item changed");

endmodule
